@@ rtl/catrfp_pkg.sv @@
`timescale 1ns / 1ps

package catrfp_pkg;

  // Item function code
  typedef enum logic {
    FUNC_BYTE    = 1'b0,
    FUNC_TIMEOUT = 1'b1
  } func_e;

  // Reported frame kind
  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_IF      = 3'd1,
    KIND_SM0     = 3'd2,
    KIND_TX      = 3'd3,
    KIND_FA      = 3'd4,
    KIND_MD0     = 3'd5,
    KIND_TIMEOUT = 3'd6
  } kind_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    kind_e       frame_kind;
    logic        changed;
    logic [29:0] frequency_hz;
    logic [3:0]  mode_index;
    logic [7:0]  s_meter;
    logic        transmitting;
    logic        online;
  } out_t;

  // ASCII characters
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_I    = 8'h49;
  localparam logic [7:0] CH_M    = 8'h4D;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_X    = 8'h58;

  // Frame lengths and byte positions
  localparam logic [4:0] LEN_MAX      = 5'd31;
  localparam logic [4:0] PREFIX_LEN   = 5'd3;
  localparam logic [4:0] IF_LEN       = 5'd27;
  localparam logic [4:0] IF_DIG_FIRST = 5'd5;
  localparam logic [4:0] IF_DIG_LAST  = 5'd13;
  localparam logic [4:0] IF_MODE_POS  = 5'd21;
  localparam logic [4:0] TX_LEN       = 5'd3;
  localparam logic [4:0] TX_MODE_POS  = 5'd2;
  localparam logic [4:0] FA_LEN       = 5'd11;
  localparam logic [4:0] FA_DIG_FIRST = 5'd2;
  localparam logic [4:0] FA_DIG_LAST  = 5'd10;
  localparam logic [4:0] MD_LEN       = 5'd4;
  localparam logic [4:0] MD_MODE_POS  = 5'd3;
  localparam logic [4:0] SM_MIN_LEN   = 5'd4;

  localparam logic [11:0] METER_SAT = 12'd256;
  localparam logic [8:0]  METER_MAX = 9'd255;

  localparam logic [3:0] MODE_NONE = 4'd0;
  localparam logic [3:0] MODE_B    = 4'd10;
  localparam logic [3:0] MODE_C    = 4'd11;
  localparam logic [3:0] MODE_D    = 4'd12;

  function automatic logic [3:0] mode_of(logic [7:0] c);
    logic [7:0] diff;
    diff = c - CH_0;
    if (c >= CH_1 && c <= CH_9) begin
      return diff[3:0];
    end else if (c == CH_B) begin
      return MODE_B;
    end else if (c == CH_C) begin
      return MODE_C;
    end else if (c == CH_D) begin
      return MODE_D;
    end
    return MODE_NONE;
  endfunction

endpackage

@@ rtl/cat_response_frame_parser_top.sv @@
// Reply parser for a transceiver control link, one received byte per item.
// A result item for a ';' or timeout item is registered in the output register,
// or in the skid entry while the output is held. Throughput: one item per
// cycle while the skid entry is empty; the per-frame parse registers update on each item.
// Reset (asynchronous, active low) clears the frame parse state, the radio
// state (frequency, mode, meter, transmit, online) and the output queue.
`timescale 1ns / 1ps

module cat_response_frame_parser_top
  import catrfp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  // Per-frame parse state: the frame is never stored, only its first three bytes, a running decimal
  // value with its valid flag, a running meter value and the position-selected mode byte.
  logic [4:0]  len_q, len_d;
  logic [23:0] prefix_q, prefix_d;
  logic [29:0] dig_q, dig_d;
  logic        dig_ok_q, dig_ok_d;
  logic [8:0]  met_q, met_d;
  logic [7:0]  mode_char_q, mode_char_d;

  // Radio state as last reported
  logic [29:0] freq_q, freq_d;
  logic [3:0]  mode_q, mode_d;
  logic [7:0]  meter_q, meter_d;
  logic        tx_q, tx_d;
  logic        online_q, online_d;

  // Output register plus one skid entry so a waiting result does not block input
  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  out_t out_data_q, out_data_d;
  out_t skid_data_q, skid_data_d;

  logic        accept;
  logic        out_take;
  logic [7:0]  rx;
  logic [4:0]  pos;
  logic [7:0]  pb0, pb1, pb2;
  logic        is_digit;
  logic [7:0]  dsub;
  logic [3:0]  dval;
  logic [29:0] dig_step;
  logic [11:0] met_wide;
  logic [11:0] met_step;
  logic [23:0] prefix_ins;
  logic        st_if, st_sm0, st_tx, st_fa, st_md0;
  logic        end_if, end_sm0, end_tx, end_fa, end_md0;
  logic [3:0]  end_mode;
  logic        res_valid;
  logic        chg;
  out_t        res;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_take = out_valid_q && !out_stall_i;
  assign rx       = in_data_i.rx_byte;
  assign pos      = len_q;

  assign pb0 = prefix_q[7:0];
  assign pb1 = prefix_q[15:8];
  assign pb2 = prefix_q[23:16];

  assign is_digit = (rx >= CH_0) && (rx <= CH_9);
  assign dsub     = rx - CH_0;
  assign dval     = dsub[3:0];

  // acc * 10 + digit, kept to 30 bits
  assign dig_step = (dig_q << 3) + (dig_q << 1) + {26'd0, dval};

  // meter * 10 + digit, saturating at 256
  assign met_wide = ({3'd0, met_q} << 3) + ({3'd0, met_q} << 1) + {8'd0, dval};
  assign met_step = (met_wide > METER_SAT) ? METER_SAT : met_wide;

  // Prefix forms seen so far; the position counts bytes before this one
  assign st_if  = (pos >= 5'd2) && (pb0 == CH_I) && (pb1 == CH_F);
  assign st_tx  = (pos >= 5'd2) && (pb0 == CH_T) && (pb1 == CH_X);
  assign st_fa  = (pos >= 5'd2) && (pb0 == CH_F) && (pb1 == CH_A);
  assign st_sm0 = (pos >= PREFIX_LEN) && (pb0 == CH_S) && (pb1 == CH_M) && (pb2 == CH_0);
  assign st_md0 = (pos >= PREFIX_LEN) && (pb0 == CH_M) && (pb1 == CH_D) && (pb2 == CH_0);

  // Exact-size forms at the frame end; SM0 needs only its prefix here
  assign end_if  = (len_q == IF_LEN) && (pb0 == CH_I) && (pb1 == CH_F);
  assign end_sm0 = st_sm0;
  assign end_tx  = (len_q == TX_LEN) && (pb0 == CH_T) && (pb1 == CH_X);
  assign end_fa  = (len_q == FA_LEN) && (pb0 == CH_F) && (pb1 == CH_A);
  assign end_md0 = (len_q == MD_LEN) && (pb0 == CH_M) && (pb1 == CH_D) && (pb2 == CH_0);

  assign end_mode = mode_of(mode_char_q);

  always_comb begin
    prefix_ins = prefix_q;
    case (pos)
      5'd0:    prefix_ins[7:0]   = rx;
      5'd1:    prefix_ins[15:8]  = rx;
      5'd2:    prefix_ins[23:16] = rx;
      default: prefix_ins = prefix_q;
    endcase
  end

  // Parse and radio state update
  always_comb begin
    len_d       = len_q;
    prefix_d    = prefix_q;
    dig_d       = dig_q;
    dig_ok_d    = dig_ok_q;
    met_d       = met_q;
    mode_char_d = mode_char_q;
    freq_d      = freq_q;
    mode_d      = mode_q;
    meter_d     = meter_q;
    tx_d        = tx_q;
    online_d    = online_q;
    res_valid   = 1'b0;
    chg         = 1'b0;
    res         = '0;
    res.frame_kind = KIND_NONE;

    if (accept) begin
      if (in_data_i.func == FUNC_TIMEOUT) begin
        // partial frame is kept
        chg            = online_q;
        online_d       = 1'b0;
        res_valid      = 1'b1;
        res.frame_kind = KIND_TIMEOUT;
      end else if (rx != CH_SEMI) begin
        if (pos < PREFIX_LEN) begin
          prefix_d = prefix_ins;
        end
        if (st_if) begin
          if (pos >= IF_DIG_FIRST && pos <= IF_DIG_LAST) begin
            if (is_digit) begin
              dig_d = dig_step;
            end else begin
              dig_ok_d = 1'b0;
            end
          end
          if (pos == IF_MODE_POS) begin
            mode_char_d = rx;
          end
        end else if (st_sm0) begin
          if (is_digit) begin
            met_d = met_step[8:0];
          end else begin
            dig_ok_d = 1'b0;
          end
        end else if (st_tx) begin
          if (pos == TX_MODE_POS) begin
            mode_char_d = rx;
          end
        end else if (st_fa) begin
          if (pos >= FA_DIG_FIRST && pos <= FA_DIG_LAST) begin
            if (is_digit) begin
              dig_d = dig_step;
            end else begin
              dig_ok_d = 1'b0;
            end
          end
        end else if (st_md0) begin
          if (pos == MD_MODE_POS) begin
            mode_char_d = rx;
          end
        end
        if (pos < LEN_MAX) begin
          len_d = pos + 5'd1;
        end
      end else begin
        // frame end; an empty frame reports nothing
        if (len_q != 5'd0) begin
          res_valid = 1'b1;
          chg       = !online_q;
          online_d  = 1'b1;
          if (end_if) begin
            res.frame_kind = KIND_IF;
            if (dig_ok_q && (dig_q != 30'd0) && (end_mode != MODE_NONE)) begin
              if (freq_q != dig_q) begin
                freq_d = dig_q;
                chg    = 1'b1;
              end
              if (mode_q != end_mode) begin
                mode_d = end_mode;
                chg    = 1'b1;
              end
            end
          end else if (end_sm0) begin
            res.frame_kind = KIND_SM0;
            if ((len_q >= SM_MIN_LEN) && dig_ok_q && (met_q <= METER_MAX) &&
                ({1'b0, meter_q} != met_q)) begin
              meter_d = met_q[7:0];
              chg     = 1'b1;
            end
          end else if (end_tx) begin
            res.frame_kind = KIND_TX;
            if (tx_q != (mode_char_q != CH_0)) begin
              tx_d = (mode_char_q != CH_0);
              chg  = 1'b1;
            end
          end else if (end_fa) begin
            res.frame_kind = KIND_FA;
            if (dig_ok_q && (dig_q != 30'd0) && (freq_q != dig_q)) begin
              freq_d = dig_q;
              chg    = 1'b1;
            end
          end else if (end_md0) begin
            res.frame_kind = KIND_MD0;
            if ((end_mode != MODE_NONE) && (mode_q != end_mode)) begin
              mode_d = end_mode;
              chg    = 1'b1;
            end
          end
        end
        len_d       = 5'd0;
        prefix_d    = 24'd0;
        dig_d       = 30'd0;
        dig_ok_d    = 1'b1;
        met_d       = 9'd0;
        mode_char_d = 8'd0;
      end
    end

    res.changed      = chg;
    res.frequency_hz = freq_d;
    res.mode_index   = mode_d;
    res.s_meter      = meter_d;
    res.transmitting = tx_d;
    res.online       = online_d;
  end

  // Output register and skid entry. Input stalls only while the skid is full.
  assign in_stall_o = skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (out_take) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_q || out_take) begin
        out_data_d  = res;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q        <= 5'd0;
      prefix_q     <= 24'd0;
      dig_q        <= 30'd0;
      dig_ok_q     <= 1'b1;
      met_q        <= 9'd0;
      mode_char_q  <= 8'd0;
      freq_q       <= 30'd0;
      mode_q       <= MODE_NONE;
      meter_q      <= 8'd0;
      tx_q         <= 1'b0;
      online_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      len_q        <= len_d;
      prefix_q     <= prefix_d;
      dig_q        <= dig_d;
      dig_ok_q     <= dig_ok_d;
      met_q        <= met_d;
      mode_char_q  <= mode_char_d;
      freq_q       <= freq_d;
      mode_q       <= mode_d;
      meter_q      <= meter_d;
      tx_q         <= tx_d;
      online_q     <= online_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // skid only fills behind a held output item
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item while the output register is empty");

  // a timeout always drops online
  a_timeout_offline : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.func == FUNC_TIMEOUT)) |=> !online_q)
    else $error("online still set after a timeout item");

  // an empty frame carries no leftover parse state
  a_empty_frame_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q == 5'd0) |-> ((prefix_q == 24'd0) && dig_ok_q && (met_q == 9'd0)))
    else $error("parse state not cleared at frame start");

  // a reported frame always leaves the link online, a timeout leaves it offline
  a_kind_online : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_data_q.frame_kind == KIND_TIMEOUT) != out_data_q.online))
    else $error("online flag does not match the frame kind");
`endif

endmodule
